// File: rtl/kfli_pkg.sv
// Shared types and constants for the keyframe linear interpolator.
`default_nettype none
package kfli_pkg;

  // Default table depth and fraction width of the blend factor.
  localparam int MAX_KEYS_DEF      = 64;
  localparam int FRACTION_BITS_DEF = 16;

  // Key count register.
  localparam int                  KEY_COUNT_W   = 7;
  localparam logic [KEY_COUNT_W-1:0] KEY_COUNT_RST = 7'd1;

  // Input commands.
  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_EVAL  = 1'b1;

  // Value components, processed one at a time by the shared multiplier.
  localparam logic [1:0] COMP_X = 2'd0;
  localparam logic [1:0] COMP_Y = 2'd1;
  localparam logic [1:0] COMP_Z = 2'd2;

  typedef struct packed {
    logic               command;
    logic [5:0]         key_index;
    logic [31:0]        key_time;
    logic signed [31:0] key_x;
    logic signed [31:0] key_y;
    logic signed [31:0] key_z;
    logic [31:0]        query_time;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [5:0]         segment_index;
    logic [16:0]        blend_factor;
  } out_item_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic       key_wr;
    logic       load_query;
    logic       factor_clear;
    logic       cap_t1;
    logic       div_init;
    logic       div_step;
    logic       seg_cap;
    logic       cap_s;
    logic       cap_e;
    logic       mul;
    logic       add;
    logic [1:0] comp;
    logic       load_out;
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic q_lt_time;
    logic need_div;
  } dp_stat_t;

endpackage
`default_nettype wire

// File: rtl/kfli_ctrl.sv
// Sequencing state machine for key writes and query evaluation.
`default_nettype none
module kfli_ctrl #(
  parameter int MAX_KEYS      = kfli_pkg::MAX_KEYS_DEF,
  parameter int FRACTION_BITS = kfli_pkg::FRACTION_BITS_DEF,
  localparam int IW = $clog2(MAX_KEYS),
  localparam int DW = $clog2(FRACTION_BITS)
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output      logic                               in_stall,
  input  wire logic                               in_command,
  output      logic                               out_valid,
  input  wire logic                               out_stall,
  input  wire logic                               cfg_wr_en,
  input  wire logic [kfli_pkg::KEY_COUNT_W-1:0]   cfg_wr_data,
  output      kfli_pkg::dp_cmd_t                  cmd,
  output      logic [IW-1:0]                      raddr,
  input  wire kfli_pkg::dp_stat_t                 stat
);

  localparam int NW = IW + 1;
  localparam int CW = (NW > kfli_pkg::KEY_COUNT_W) ? NW : kfli_pkg::KEY_COUNT_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SRD  = 4'd1;
  localparam logic [3:0] S_SCMP = 4'd2;
  localparam logic [3:0] S_T1   = 4'd3;
  localparam logic [3:0] S_T2   = 4'd4;
  localparam logic [3:0] S_DIVI = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_VRD0 = 4'd7;
  localparam logic [3:0] S_VRD1 = 4'd8;
  localparam logic [3:0] S_VCAP = 4'd9;
  localparam logic [3:0] S_MUL  = 4'd10;
  localparam logic [3:0] S_ADD  = 4'd11;
  localparam logic [3:0] S_DONE = 4'd12;

  logic [3:0]                       state, state_next;
  logic [kfli_pkg::KEY_COUNT_W-1:0] key_count;
  logic [NW-1:0]                    n, n_next;
  logic [IW-1:0]                    idx, idx_next;
  logic [DW-1:0]                    dcnt, dcnt_next;
  logic [1:0]                       comp, comp_next;
  logic                             out_valid_next;
  logic                             in_accept;
  logic [IW-1:0]                    idx_inc;
  logic [CW-1:0]                    kc_ext;
  logic [NW-1:0]                    n_calc;

  assign in_stall  = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign idx_inc   = idx + IW'(1);
  assign kc_ext    = CW'(key_count);

  // Clamp the key count into one to the table depth.
  always_comb begin
    if (kc_ext == '0) begin
      n_calc = NW'(1);
    end else if (kc_ext > CW'(MAX_KEYS)) begin
      n_calc = NW'(MAX_KEYS);
    end else begin
      n_calc = NW'(kc_ext);
    end
  end

  always_comb begin
    state_next     = state;
    n_next         = n;
    idx_next       = idx;
    dcnt_next      = dcnt;
    comp_next      = comp;
    cmd            = '0;
    cmd.comp       = comp;
    raddr          = idx;
    out_valid_next = out_valid && out_stall;
    case (state)
      S_IDLE: begin
        if (in_accept) begin
          if (in_command == kfli_pkg::CMD_WRITE) begin
            cmd.key_wr = 1'b1;
          end else begin
            cmd.load_query = 1'b1;
            n_next         = n_calc;
            idx_next       = '0;
            if (n_calc == NW'(1)) begin
              cmd.factor_clear = 1'b1;
              state_next       = S_VRD0;
            end else begin
              state_next = S_SRD;
            end
          end
        end
      end
      S_SRD: begin
        raddr      = idx_inc;
        state_next = S_SCMP;
      end
      S_SCMP: begin
        if (stat.q_lt_time) begin
          state_next = S_T1;
        end else if (NW'(idx_inc) == n - NW'(1)) begin
          idx_next   = '0;
          state_next = S_T1;
        end else begin
          idx_next   = idx_inc;
          state_next = S_SRD;
        end
      end
      S_T1: begin
        state_next = S_T2;
      end
      S_T2: begin
        raddr      = idx_inc;
        cmd.cap_t1 = 1'b1;
        state_next = S_DIVI;
      end
      S_DIVI: begin
        cmd.div_init = 1'b1;
        dcnt_next    = '0;
        state_next   = stat.need_div ? S_DIV : S_VRD0;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        dcnt_next    = dcnt + DW'(1);
        if (dcnt == DW'(FRACTION_BITS - 1)) begin
          state_next = S_VRD0;
        end
      end
      S_VRD0: begin
        cmd.seg_cap = 1'b1;
        state_next  = S_VRD1;
      end
      S_VRD1: begin
        raddr      = idx_inc;
        cmd.cap_s  = 1'b1;
        state_next = S_VCAP;
      end
      S_VCAP: begin
        cmd.cap_e  = 1'b1;
        comp_next  = kfli_pkg::COMP_X;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_ADD;
      end
      S_ADD: begin
        cmd.add = 1'b1;
        if (comp == kfli_pkg::COMP_Z) begin
          state_next = S_DONE;
        end else begin
          comp_next  = comp + 2'd1;
          state_next = S_MUL;
        end
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.load_out   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      key_count <= kfli_pkg::KEY_COUNT_RST;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
      if (cfg_wr_en) begin
        key_count <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    n    <= n_next;
    idx  <= idx_next;
    dcnt <= dcnt_next;
    comp <= comp_next;
  end

endmodule
`default_nettype wire

// File: rtl/kfli_dp.sv
// Key tables, divider, shared multiplier and output register.
`default_nettype none
module kfli_dp #(
  parameter int MAX_KEYS      = kfli_pkg::MAX_KEYS_DEF,
  parameter int FRACTION_BITS = kfli_pkg::FRACTION_BITS_DEF,
  localparam int IW = $clog2(MAX_KEYS)
) (
  input  wire logic                clk,
  input  wire kfli_pkg::in_item_t  in_data,
  input  wire kfli_pkg::dp_cmd_t   cmd,
  input  wire logic [IW-1:0]       raddr,
  output      kfli_pkg::dp_stat_t  stat,
  output      kfli_pkg::out_item_t out_data
);

  localparam int FW = FRACTION_BITS + 1;
  localparam int PW = 33 + FRACTION_BITS + 2;
  localparam int SW = PW + 1;
  localparam logic [FW-1:0] ONE = {1'b1, {FRACTION_BITS{1'b0}}};

  logic [31:0] tmem [MAX_KEYS];
  logic [95:0] vmem [MAX_KEYS];
  logic [31:0] trdata;
  logic [95:0] vrdata;

  logic [31:0]          query, t1, rem, den_r;
  logic [FW-1:0]        factor;
  logic [95:0]          s_r, e_r;
  logic [IW-1:0]        idx_r;
  logic signed [PW-1:0] prod;
  logic signed [31:0]   res_x, res_y, res_z;

  logic               wr_ok;
  logic [31:0]        num, den;
  logic [32:0]        rem_sh;
  logic               rem_ge;
  logic signed [31:0] s_c, e_c;
  logic signed [32:0] diff;
  logic signed [FW:0] fac_s;
  logic signed [PW-1:0] shifted;
  logic signed [SW-1:0] sum;
  logic signed [31:0] sat;

  // Key writes and the shared read port.
  assign wr_ok = cmd.key_wr && (32'(in_data.key_index) < 32'(MAX_KEYS));

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      tmem[IW'(in_data.key_index)] <= in_data.key_time;
      vmem[IW'(in_data.key_index)] <= {in_data.key_x, in_data.key_y, in_data.key_z};
    end
    trdata <= tmem[raddr];
    vrdata <= vmem[raddr];
  end

  // Segment classification, trdata holds the end key time here.
  assign num           = query - t1;
  assign den           = trdata - t1;
  assign stat.q_lt_time = query < trdata;
  assign stat.need_div  = (t1 <= query) && (trdata > t1) && (num < den);

  // Restoring divider step.
  assign rem_sh = {rem, 1'b0};
  assign rem_ge = rem_sh >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (cmd.load_query) begin
      query <= in_data.query_time;
    end
    if (cmd.cap_t1) begin
      t1 <= trdata;
    end
    if (cmd.factor_clear) begin
      factor <= '0;
    end else if (cmd.div_init) begin
      rem   <= num;
      den_r <= den;
      if (t1 > query) begin
        factor <= '0;
      end else if (trdata == t1) begin
        factor <= ONE;
      end else if (trdata < t1) begin
        factor <= (num == '0) ? '0 : ONE;
      end else if (num >= den) begin
        factor <= ONE;
      end else begin
        factor <= '0;
      end
    end else if (cmd.div_step) begin
      rem    <= rem_ge ? 32'(rem_sh - {1'b0, den_r}) : rem_sh[31:0];
      factor <= {factor[FW-2:0], rem_ge};
    end
  end

  // Component select for the shared multiplier.
  always_comb begin
    case (cmd.comp)
      kfli_pkg::COMP_X: begin
        s_c = s_r[95:64];
        e_c = e_r[95:64];
      end
      kfli_pkg::COMP_Y: begin
        s_c = s_r[63:32];
        e_c = e_r[63:32];
      end
      kfli_pkg::COMP_Z: begin
        s_c = s_r[31:0];
        e_c = e_r[31:0];
      end
      default: begin
        s_c = s_r[95:64];
        e_c = e_r[95:64];
      end
    endcase
  end

  // Drop the end key when the factor is zero: it may never have been written.
  assign diff    = (factor == '0) ? '0 : (33'(e_c) - 33'(s_c));
  assign fac_s   = {1'b0, factor};
  assign shifted = prod >>> FRACTION_BITS;
  assign sum     = SW'(s_c) + SW'(shifted);

  always_comb begin
    if (!sum[SW-1] && (|sum[SW-2:31])) begin
      sat = 32'sh7FFF_FFFF;
    end else if (sum[SW-1] && !(&sum[SW-2:31])) begin
      sat = 32'sh8000_0000;
    end else begin
      sat = sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.seg_cap) begin
      idx_r <= raddr;
    end
    if (cmd.cap_s) begin
      s_r <= vrdata;
    end
    if (cmd.cap_e) begin
      e_r <= vrdata;
    end
    if (cmd.mul) begin
      prod <= diff * fac_s;
    end
    if (cmd.add) begin
      case (cmd.comp)
        kfli_pkg::COMP_X: res_x <= sat;
        kfli_pkg::COMP_Y: res_y <= sat;
        kfli_pkg::COMP_Z: res_z <= sat;
        default:          res_x <= sat;
      endcase
    end
    if (cmd.load_out) begin
      out_data.out_x         <= res_x;
      out_data.out_y         <= res_y;
      out_data.out_z         <= res_z;
      out_data.segment_index <= 6'(idx_r);
      out_data.blend_factor  <= 17'(factor);
    end
  end

endmodule
`default_nettype wire

// File: rtl/keyframe_linear_interpolator_core.sv
// Top level of the keyframe linear interpolator: controller plus datapath.
// An evaluate searches the keys for its segment (when two or more are in use), divides for
//   the blend factor bit by bit when a division is needed, then multiplies and adds x, y
//   and z in turn. A key write yields no result and frees the input in the next cycle.
// Throughput: one item in flight; input stalls until the result is loaded into the output
//   register, which waits while a previous result is stalled. Reset (rst, synchronous): idle
//   sequencer, out_valid low, key_count 1; key tables are not cleared and must be written first.
`default_nettype none
module keyframe_linear_interpolator_core #(
  parameter int MAX_KEYS      = kfli_pkg::MAX_KEYS_DEF,
  parameter int FRACTION_BITS = kfli_pkg::FRACTION_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output      logic                             in_stall,
  input  wire kfli_pkg::in_item_t               in_data,
  output      logic                             out_valid,
  input  wire logic                             out_stall,
  output      kfli_pkg::out_item_t              out_data,
  input  wire logic                             cfg_wr_en,
  input  wire logic [kfli_pkg::KEY_COUNT_W-1:0] cfg_wr_data
);

  localparam int IW = $clog2(MAX_KEYS);

  kfli_pkg::dp_cmd_t  cmd;
  kfli_pkg::dp_stat_t stat;
  logic [IW-1:0]      raddr;

  // Sequencer: owns the key count register, the handshakes and the
  // search / divide / multiply schedule.
  kfli_ctrl #(
    .MAX_KEYS      (MAX_KEYS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_command  (in_data.command),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .raddr       (raddr),
    .stat        (stat)
  );

  // Datapath: key tables with a registered read port, the restoring
  // divider for the blend factor, one multiplier shared by x, y and z,
  // and the output register that holds a result until its transfer.
  kfli_dp #(
    .MAX_KEYS      (MAX_KEYS),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk      (clk),
    .in_data  (in_data),
    .cmd      (cmd),
    .raddr    (raddr),
    .stat     (stat),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

// File: rtl/kfli_checker.sv
// Port-level checks for the keyframe linear interpolator, bound to the top level.
`default_nettype none
module kfli_checker #(
  parameter int FRACTION_BITS = kfli_pkg::FRACTION_BITS_DEF
) (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             in_valid,
  input wire logic                             in_stall,
  input wire kfli_pkg::in_item_t               in_data,
  input wire logic                             out_valid,
  input wire logic                             out_stall,
  input wire kfli_pkg::out_item_t              out_data
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // Drop output valid after reset.
  a_rst_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // A key write leaves the input free in the next cycle.
  a_write_fast: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (in_data.command == kfli_pkg::CMD_WRITE) |=> !in_stall)
    else $error("key write held the input");

  // An evaluate occupies the block.
  a_eval_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (in_data.command == kfli_pkg::CMD_EVAL) |=> in_stall)
    else $error("evaluate did not hold the input");

  // Blend factor never exceeds one.
  a_factor_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (32'(out_data.blend_factor) <= (32'd1 << FRACTION_BITS)))
    else $error("blend factor above one");

endmodule

bind keyframe_linear_interpolator_core kfli_checker #(
  .FRACTION_BITS (FRACTION_BITS)
) u_kfli_checker (.*);
`default_nettype wire

// File: dv/keyframe_linear_interpolator_core_tb.sv
// Self-checking testbench for the keyframe linear interpolator core.
module keyframe_linear_interpolator_core_tb;

  // Table depth and factor width match the defaults of the block under test.
  localparam int     TABLE_DEPTH = kfli_pkg::MAX_KEYS_DEF;
  localparam int     FRAC        = kfli_pkg::FRACTION_BITS_DEF;
  localparam longint BLEND_ONE   = longint'(1) << FRAC;
  localparam longint VAL_MAX     = 64'sd2147483647;
  localparam longint VAL_MIN     = -64'sd2147483648;
  localparam int     VAL_TOP     = 32'sh7FFF_FFFF;
  localparam int     VAL_BOTTOM  = int'(32'h8000_0000);

  // Worst evaluate latency of the top level (full table), plus slack.
  localparam int SETTLE_CYCLES    = 2 * (TABLE_DEPTH - 1) + FRAC + 24;
  // Long receiver hold-off: well past one evaluate, so the block must stall its input.
  localparam int LONG_HOLD_CYCLES = 400;

  typedef enum int {STALL_OFF, STALL_COIN, STALL_HEAVY, STALL_EVERY_THIRD} stall_mode_t;

  logic                val_clk_unused_guard;
  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  kfli_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  kfli_pkg::out_item_t out_data;
  logic                cfg_wr_en = 1'b0;
  logic [kfli_pkg::KEY_COUNT_W-1:0] cfg_wr_data = '0;

  keyframe_linear_interpolator_core dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  assign val_clk_unused_guard = clk;

  initial begin
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Key table mirror and interpolation predictor.
  // The mirror is updated in transfer order, so every evaluate sees exactly
  // the keys the block holds when it takes the query.
  // ---------------------------------------------------------------------------
  bit [31:0] key_times [TABLE_DEPTH];
  int        key_vals  [TABLE_DEPTH][3];
  int        keys_in_use = 1;
  kfli_pkg::out_item_t predicted_frames [$];

  function automatic kfli_pkg::out_item_t interpolate(bit [31:0] q);
    int        n;
    int        seg;
    longint    blend;
    longint    s;
    longint    e;
    longint    r;
    longint    comp_out [3];
    bit [63:0] t1;
    bit [63:0] t2;
    bit [63:0] num;
    bit [63:0] den;
    kfli_pkg::out_item_t f;
    // Zero keys count as one; counts past the table depth saturate.
    n = keys_in_use;
    if (n == 0) n = 1;
    if (n > TABLE_DEPTH) n = TABLE_DEPTH;
    seg   = 0;
    blend = 0;
    if (n > 1) begin
      // First segment whose end key lies after the query; segment 0 if none does.
      for (int i = 0; i + 1 < n; i++) begin
        if (q < key_times[i + 1]) begin
          seg = i;
          break;
        end
      end
      t1 = 64'(key_times[seg]);
      t2 = 64'(key_times[seg + 1]);
      // A query ahead of the start key keeps a zero factor.
      if (t1 <= 64'(q)) begin
        num = 64'(q) - t1;
        if (t2 == t1) begin
          blend = BLEND_ONE;
        end else if (t2 < t1) begin
          blend = (num == 0) ? 0 : BLEND_ONE;
        end else begin
          den   = t2 - t1;
          blend = (num > den) ? BLEND_ONE : longint'((num << FRAC) / den);
        end
      end
    end
    for (int c = 0; c < 3; c++) begin
      s = longint'(key_vals[seg][c]);
      r = s;
      if (blend != 0) begin
        e = longint'(key_vals[seg + 1][c]);
        // Arithmetic shift drops the low bits, rounding toward minus infinity.
        r = s + (((e - s) * blend) >>> FRAC);
      end
      if (r > VAL_MAX) r = VAL_MAX;
      if (r < VAL_MIN) r = VAL_MIN;
      comp_out[c] = r;
    end
    f.out_x         = comp_out[0][31:0];
    f.out_y         = comp_out[1][31:0];
    f.out_z         = comp_out[2][31:0];
    f.segment_index = seg[5:0];
    f.blend_factor  = blend[16:0];
    return f;
  endfunction

  function automatic void absorb_item(kfli_pkg::in_item_t it);
    if (it.command == kfli_pkg::CMD_WRITE) begin
      key_times[it.key_index]   = it.key_time;
      key_vals[it.key_index][0] = it.key_x;
      key_vals[it.key_index][1] = it.key_y;
      key_vals[it.key_index][2] = it.key_z;
    end else begin
      predicted_frames = {predicted_frames, interpolate(it.query_time)};
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Input side: acceptance tracking and the bursty driver.
  // ---------------------------------------------------------------------------
  kfli_pkg::in_item_t outbound_items [$];
  int       items_queued = 0;
  int       items_taken  = 0;
  bit       in_fire      = 1'b0;
  int       burst_left   = 0;
  int       gap_left     = 0;

  // Record each input transfer at the edge that takes it.
  always @(posedge clk) begin
    in_fire = !rst && in_valid && !in_stall;
    if (in_fire) begin
      items_taken++;
      absorb_item(in_data);
    end
  end

  // Drive at the falling edge: hold a stalled transfer, otherwise advance
  // through the queue in bursts separated by random gaps.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_fire) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (outbound_items.size() != 0) begin
        in_data  <= outbound_items.pop_front();
        in_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          // Now and then a long burst, and now and then no gap before it.
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(0, 15);
          gap_left   = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 20);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output side: stall pattern and result checking.
  // ---------------------------------------------------------------------------
  stall_mode_t stall_mode  = STALL_OFF;
  int          mode_left   = 200;
  int          stall_tick  = 0;
  int          hold_left   = 0;
  int          long_holds  = 0;
  int          frames_seen = 0;
  int          mismatches  = 0;
  bit          closing     = 1'b0;

  always @(negedge clk) begin
    if (rst || closing) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (long_holds < 2 && outbound_items.size() > 30 &&
                 frames_seen > 16 + 400 * long_holds) begin
      // Hold off long enough that the block fills up and stalls its input.
      hold_left = LONG_HOLD_CYCLES - 1;
      long_holds++;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode = stall_mode_t'($urandom_range(0, 3));
        mode_left  = $urandom_range(32, 300);
      end else begin
        mode_left--;
      end
      stall_tick++;
      case (stall_mode)
        STALL_OFF:   out_stall <= 1'b0;
        STALL_COIN:  out_stall <= 1'($urandom_range(0, 1));
        STALL_HEAVY: out_stall <= ($urandom_range(0, 4) != 0);
        default:     out_stall <= (stall_tick % 3 == 0);
      endcase
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%08h, got 0x%08h", name, want, got);
      mismatches++;
    end
  endtask

  // Compare each result transfer with the oldest prediction.
  always @(posedge clk) begin : frame_check
    kfli_pkg::out_item_t want;
    if (!rst && out_valid && !out_stall) begin
      frames_seen++;
      if (predicted_frames.size() == 0) begin
        $error("result with nothing expected: segment_index %0d, blend_factor 0x%05h",
               out_data.segment_index, out_data.blend_factor);
        mismatches++;
      end else begin
        want = predicted_frames.pop_front();
        check_field("out_x", want.out_x, out_data.out_x);
        check_field("out_y", want.out_y, out_data.out_y);
        check_field("out_z", want.out_z, out_data.out_z);
        check_field("segment_index", 32'(want.segment_index), 32'(out_data.segment_index));
        check_field("blend_factor", 32'(want.blend_factor), 32'(out_data.blend_factor));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus.
  // laid_times tracks key times as queued, so queries can aim at segments.
  // ---------------------------------------------------------------------------
  bit [31:0] laid_times [TABLE_DEPTH];

  task automatic push_write(int idx, bit [31:0] t, int x, int y, int z);
    kfli_pkg::in_item_t it;
    it.command    = kfli_pkg::CMD_WRITE;
    it.key_index  = idx[5:0];
    it.key_time   = t;
    it.key_x      = x;
    it.key_y      = y;
    it.key_z      = z;
    it.query_time = $urandom;
    outbound_items = {outbound_items, it};
    laid_times[idx] = t;
    items_queued++;
  endtask

  task automatic push_query(bit [31:0] q);
    kfli_pkg::in_item_t it;
    it.command    = kfli_pkg::CMD_EVAL;
    it.key_index  = 6'($urandom);
    it.key_time   = $urandom;
    it.key_x      = $urandom;
    it.key_y      = $urandom;
    it.key_z      = $urandom;
    it.query_time = q;
    outbound_items = {outbound_items, it};
    items_queued++;
  endtask

  function automatic int pick_value();
    case ($urandom_range(0, 5))
      0:       return VAL_TOP;
      1:       return VAL_BOTTOM;
      2:       return 0;
      3, 4:    return int'($urandom_range(0, 32'h001F_FFFF)) - 32'sh0010_0000;
      default: return int'($urandom);
    endcase
  endfunction

  function automatic bit [31:0] time_step();
    case ($urandom_range(0, 7))
      0:       return 32'd0;  // repeated time: zero-width segment
      1:       return $urandom_range(1, 16);
      2:       return $urandom_range(32'h0100_0000, 32'h0400_0000);
      default: return $urandom_range(1, 32'h0004_0000);
    endcase
  endfunction

  function automatic bit [31:0] pick_query(int n_eff);
    int        j;
    bit [31:0] a;
    bit [31:0] b;
    j = $urandom_range(0, n_eff - 1);
    a = laid_times[j];
    b = (j + 1 < n_eff) ? laid_times[j + 1] : a;
    case ($urandom_range(0, 7))
      0:       return a;
      1:       return a - 1;
      2, 3:    return (b > a) ? a + $urandom_range(0, b - a) : a + $urandom_range(0, 64);
      4:       return laid_times[n_eff - 1] + $urandom_range(0, 4096);
      5:       return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Lay a run of keys with non-decreasing times (a step may be zero), starting from the key below it.
  task automatic lay_keys(int first, int last);
    bit [31:0] t;
    if (first == 0) begin
      t = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0010_0000);
    end else begin
      t = laid_times[first - 1];
    end
    for (int j = first; j <= last; j++) begin
      if (j != 0) t = t + time_step();
      push_write(j, t, pick_value(), pick_value(), pick_value());
    end
  endtask

  // Hold until every queued item is taken and every result is in; optionally
  // let the block settle so a last key write has surely landed.
  task automatic wait_for_results(bit settle);
    do @(negedge clk);
    while (items_taken != items_queued || predicted_frames.size() != 0);
    if (settle) repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic set_key_count(int kc);
    wait_for_results(1'b1);
    cfg_wr_data <= kc[kfli_pkg::KEY_COUNT_W-1:0];
    cfg_wr_en   <= 1'b1;
    @(negedge clk);
    cfg_wr_en   <= 1'b0;
    keys_in_use = kc;
  endtask

  task automatic directed_checks();
    // Single key: key 0 comes back untouched.
    set_key_count(1);
    push_write(0, 32'h0000_0000, VAL_TOP, VAL_BOTTOM, 0);
    push_query(32'h1234_5678);
    // Zero key count behaves as a single key.
    set_key_count(0);
    push_query(32'hFFFF_FFFF);
    // Full-range segment: start exact, midpoint, and a query at the end key.
    set_key_count(2);
    push_write(1, 32'hFFFF_FFFF, VAL_BOTTOM, VAL_TOP, -1);
    push_query(32'h0000_0000);
    push_query(32'h8000_0000);
    push_query(32'hFFFF_FFFF);
    // Zero-width segment, then a query ahead of the start key.
    push_write(0, 100, 65536, -65536, 7);
    push_write(1, 100, -3, 3, 123456);
    push_query(100);
    push_query(99);
    // Next key earlier than the start key.
    push_write(0, 500, VAL_TOP, 12345, -77);
    push_write(1, 100, VAL_BOTTOM, -54321, 88);
    push_query(500);
    push_query(600);
    push_query(50);
    // Three keys: both segments, exact key time, factor above one.
    set_key_count(3);
    push_write(0, 1000, -65536, 1 << 20, VAL_TOP);
    push_write(1, 1500, 65536, -(1 << 20), 0);
    push_write(2, 2000, 3 << 16, 5, VAL_BOTTOM);
    push_query(1250);
    push_query(1700);
    push_query(1000);
    push_query(5000);
  endtask

  // One setting of the key count: fill the table it covers, then mostly
  // well-formed queries with some relaid segments, stray writes and broken
  // orderings, and one pause of the sender partway through.
  task automatic random_phase(int kc, int budget);
    int n_eff;
    int start;
    int pause_at;
    int lo;
    int hi;
    int j;
    n_eff = (kc == 0) ? 1 : (kc > TABLE_DEPTH) ? TABLE_DEPTH : kc;
    set_key_count(kc);
    start    = items_queued;
    pause_at = $urandom_range(budget / 4, 3 * budget / 4);
    lay_keys(0, n_eff - 1);
    while (items_queued - start < budget) begin
      if (pause_at >= 0 && items_queued - start >= pause_at) begin
        pause_at = -1;
        wait_for_results(1'b0);
      end
      j = (n_eff > 1) ? $urandom_range(1, n_eff - 1) : 1;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: push_query(pick_query(n_eff));
        6: begin
          lo = $urandom_range(0, n_eff - 1);
          hi = lo + $urandom_range(0, 3);
          if (hi > TABLE_DEPTH - 1) hi = TABLE_DEPTH - 1;
          lay_keys(lo, hi);
        end
        7: push_write($urandom_range(0, TABLE_DEPTH - 1), $urandom,
                      pick_value(), pick_value(), pick_value());
        8: push_write(j, laid_times[j - 1], pick_value(), pick_value(), pick_value());
        default: push_write(j, laid_times[j - 1] - $urandom_range(1, 1000),
                            pick_value(), pick_value(), pick_value());
      endcase
    end
  endtask

  initial begin : stimulus
    int plan [14];
    int kc;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    directed_checks();
    // Extremes of the key count first, then small random counts.
    plan = '{64, 2, 127, 5, 0, 3, 65, 1, 8, 100, 4, 2, 6, 7};
    foreach (plan[p]) begin
      kc = (p >= 11) ? $urandom_range(2, 12) : plan[p];
      random_phase(kc, (kc > 12) ? 110 : 85);
    end
    wait_for_results(1'b0);
    // Drop all stalls so a stray result cannot hide behind one.
    closing = 1'b1;
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("keyframe_linear_interpolator_core_tb: done, clean");
    end else begin
      $display("keyframe_linear_interpolator_core_tb: done, errors");
    end
    $finish;
  end

  // Watchdog: several times the slowest legal run.
  initial begin
    #30_000_000;
    $display("keyframe_linear_interpolator_core_tb: done, errors");
    $finish;
  end

endmodule

// File: filelist.f
rtl/kfli_pkg.sv
rtl/kfli_ctrl.sv
rtl/kfli_dp.sv
rtl/keyframe_linear_interpolator_core.sv
rtl/kfli_checker.sv
dv/keyframe_linear_interpolator_core_tb.sv
